// File: rtl/core/clutch_torque_thermal_step_top_defines.svh
// assertion helpers, clocked on i_clk, quiet while i_rst_n is low
`ifndef CLUTCH_TORQUE_THERMAL_STEP_TOP_DEFINES_SVH
`define CLUTCH_TORQUE_THERMAL_STEP_TOP_DEFINES_SVH

// same-cycle implication
`define CTTS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ctts_pkg.sv
package ctts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_COEF  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_FR  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_MASS  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_HEAT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_COEF  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEALTH     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TEMP = 4'd7;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef logic signed [33:0] t_op;

    typedef struct packed {
        logic [31:0]        time_step;
        logic signed [31:0] engine_torque;
        logic signed [31:0] engine_speed;
        logic signed [31:0] gearbox_speed;
        logic signed [31:0] pedal_position;
        logic signed [31:0] ambient_temp;
    } t_in;

    typedef struct packed {
        logic [22:0]        engagement_percent;
        logic signed [31:0] passed_torque;
        logic signed [31:0] slip_speed;
        logic signed [31:0] disc_temp;
    } t_out;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctl;

    // signed result from a magnitude and a sign, saturated to 32 bits
    function automatic logic signed [31:0] from_mag(input logic [63:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            r = (m >= 64'h8000_0000) ? S32_MIN : -$signed(m[31:0]);
        end else begin
            r = (m > 64'h7FFF_FFFF) ? S32_MAX : $signed(m[31:0]);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/ctts_mul.sv
module ctts_mul import ctts_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  t_op                i_a,
    input  t_op                i_b,
    output logic signed [31:0] o_p
);

    logic [33:0] a_abs;
    logic [33:0] b_abs;
    logic [63:0] r_prod;
    logic        r_neg;

    assign a_abs = i_a[33] ? 34'(-i_a) : 34'(i_a);
    assign b_abs = i_b[33] ? 34'(-i_b) : 34'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= a_abs[31:0] * b_abs[31:0];
        r_neg  <= i_a[33] ^ i_b[33];
    end

    assign o_p = from_mag(r_prod >> FRAC_BITS, r_neg);

endmodule

// File: rtl/core/ctts_div.sv
module ctts_div import ctts_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_ctl                i_ctl,
    input  logic [32+FRAC_BITS-1:0] i_dividend,
    input  logic [31:0]             i_divisor,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_dvd;
    logic [31:0]   r_rem;
    logic [31:0]   r_dvs;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   rem_sh;
    logic          ge;

    assign rem_sh = {r_rem, r_dvd[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_neg  <= i_ctl.neg;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
                r_dvd <= {r_dvd[DW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = from_mag(64'(r_dvd), r_neg);

endmodule

// File: rtl/core/clutch_torque_thermal_step_top.sv
// Friction clutch tick: each input beat yields one output beat with engagement, clamped
// torque, slip speed and the updated disc temperature, which the block keeps between
// beats. Work runs through one shared 32x32 multiplier (up to thirteen products plus a
// step to latch the engagement, which comes from a reciprocal multiply by 1/100) and
// one restoring divider that retires one quotient bit a cycle (two divisions, both
// skipped when the heat capacity is zero). The block takes no new item until the last
// one is in the output register, so a stalled output holds it back. A finished beat
// waits in the output register while the next item is taken. Config writes are taken
// only while the block is idle; writing start_temperature also loads the disc
// temperature.
`include "clutch_torque_thermal_step_top_defines.svh"

module clutch_torque_thermal_step_top import ctts_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int DW = 32 + FRAC_BITS;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] FULL = 32'(64'd100 << FRAC_BITS);
    localparam logic [33:0] KRAD =
        34'(((64'd104719755 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] PCT_DIV = 32'd100;
    localparam logic [63:0] RECIP_100 = 64'd2748779070;
    localparam int RECIP_SH = 38;

    localparam logic [3:0] K_E   = 4'd0;
    localparam logic [3:0] K_MT1 = 4'd1;
    localparam logic [3:0] K_MT  = 4'd2;
    localparam logic [3:0] K_W   = 4'd3;
    localparam logic [3:0] K_S1  = 4'd4;
    localparam logic [3:0] K_S2  = 4'd5;
    localparam logic [3:0] K_SY  = 4'd6;
    localparam logic [3:0] K_TT  = 4'd7;
    localparam logic [3:0] K_PW  = 4'd8;
    localparam logic [3:0] K_EN  = 4'd9;
    localparam logic [3:0] K_HI  = 4'd10;
    localparam logic [3:0] K_CAP = 4'd11;
    localparam logic [3:0] K_DH  = 4'd12;
    localparam logic [3:0] K_C1  = 4'd13;
    localparam logic [3:0] K_C2  = 4'd14;
    localparam logic [3:0] K_DC  = 4'd15;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_MULW = 6'b000100,
        S_DIV  = 6'b001000,
        S_DIVW = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? S32_MIN : S32_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;
    logic r_ovalid;
    t_out r_out;
    t_in r_in;

    logic [31:0]        r_max_torque;
    logic [31:0]        r_slip_coef;
    logic [16:0]        r_energy_fr;
    logic [31:0]        r_disc_mass;
    logic [31:0]        r_spec_heat;
    logic [31:0]        r_cool_coef;
    logic [FRAC_BITS:0] r_health;
    logic signed [31:0] r_start_temp;
    logic signed [31:0] r_temp;

    logic signed [31:0] r_e, r_maxt, r_w, r_t1, r_sync, r_tt, r_en, r_hi, r_cap, r_cool;
    logic signed [33:0] r_pw;

    logic signed [31:0] pedal_c, eng_pct, e_q, slip_sat, diff, m, q;
    logic signed [32:0] slip33;
    t_op                mul_a, mul_b;
    logic signed [31:0] tt_sum, tt_clamp, neg_maxt, fin_pre, fin_temp;
    logic [31:0]        cool_abs, health_in;
    logic               div_busy, div_done, fin, next_div;
    logic [DW-1:0]      div_dividend;
    logic [31:0]        div_divisor;
    t_div_ctl           div_ctl;

    // input-side derived values
    always_comb begin
        if (r_in.pedal_position < 0) begin
            pedal_c = '0;
        end else if (r_in.pedal_position > FULL) begin
            pedal_c = FULL;
        end else begin
            pedal_c = r_in.pedal_position;
        end
    end
    assign eng_pct  = FULL - pedal_c;
    // engagement by reciprocal multiply, exact for the clamped pedal range
    assign e_q      = $signed(32'((64'(eng_pct) * RECIP_100) >> RECIP_SH));
    assign slip33   = 33'(r_in.engine_speed) - 33'(r_in.gearbox_speed);
    assign slip_sat = sat33(slip33);
    assign diff     = sat33(33'(r_temp) - 33'(r_in.ambient_temp));

    always_comb begin
        case (r_step)
            K_MT1: begin mul_a = $signed({2'b00, r_max_torque}); mul_b = 34'(r_e); end
            K_MT: begin
                mul_a = 34'(r_t1);
                mul_b = $signed({{(33-FRAC_BITS){1'b0}}, r_health});
            end
            K_W:   begin mul_a = 34'(slip33); mul_b = $signed(KRAD); end
            K_S1: begin
                mul_a = $signed({2'b00, r_slip_coef});
                mul_b = $signed({{(33-FRAC_BITS){1'b0}}, r_health});
            end
            K_S2:  begin mul_a = 34'(r_t1); mul_b = 34'(r_w); end
            K_SY:  begin mul_a = 34'(r_t1); mul_b = 34'(r_e); end
            K_TT:  begin mul_a = 34'(r_in.engine_torque); mul_b = 34'(r_e); end
            K_PW:  begin mul_a = 34'(r_tt); mul_b = 34'(r_w); end
            K_EN:  begin mul_a = r_pw; mul_b = $signed({2'b00, r_in.time_step}); end
            K_HI:  begin mul_a = 34'(r_en); mul_b = $signed({17'd0, r_energy_fr}); end
            K_CAP: begin
                mul_a = $signed({2'b00, r_disc_mass});
                mul_b = $signed({2'b00, r_spec_heat});
            end
            K_C1:  begin mul_a = $signed({2'b00, r_cool_coef}); mul_b = 34'(diff); end
            K_C2:  begin mul_a = 34'(r_t1); mul_b = $signed({2'b00, r_in.time_step}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    ctts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (m)
    );

    assign cool_abs = r_cool[31] ? 32'(-33'(r_cool)) : r_cool;

    always_comb begin
        case (r_step)
            K_DH: begin
                div_dividend = {r_hi, {FRAC_BITS{1'b0}}};
                div_divisor  = r_cap;
                div_ctl.neg  = 1'b0;
            end
            K_DC: begin
                div_dividend = {cool_abs, {FRAC_BITS{1'b0}}};
                div_divisor  = r_cap;
                div_ctl.neg  = r_cool[31];
            end
            default: begin
                div_dividend = '0;
                div_divisor  = PCT_DIV;
                div_ctl.neg  = 1'b0;
            end
        endcase
        div_ctl.start = (r_state == S_DIV);
    end

    ctts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (q)
    );

    // torque clamp against +/- max torque
    assign tt_sum   = sat33(33'(m) + 33'(r_sync));
    assign neg_maxt = -r_maxt;
    always_comb begin
        if (tt_sum > r_maxt) begin
            tt_clamp = r_maxt;
        end else if (tt_sum < neg_maxt) begin
            tt_clamp = neg_maxt;
        end else begin
            tt_clamp = tt_sum;
        end
    end

    // final temperature with ambient floor
    assign fin_pre  = (r_step == K_DC) ? sat33(33'(r_temp) - 33'(q)) : r_temp;
    assign fin_temp = (fin_pre < r_in.ambient_temp) ? r_in.ambient_temp : fin_pre;
    assign fin = ((r_state == S_MULW) && (r_step == K_CAP) && (m == 0)) ||
                 ((r_state == S_DIVW) && div_done && (r_step == K_DC));
    assign next_div = (r_step + 4'd1 == K_DH) || (r_step + 4'd1 == K_DC);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL;
                    n_step  = K_E;
                end
            end
            S_MUL: n_state = S_MULW;
            S_MULW: begin
                if (fin) begin
                    n_state = S_OUT;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = next_div ? S_DIV : S_MUL;
                end
            end
            S_DIV: n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    if (fin) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 4'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign health_in = {15'd0, i_cfg_data[16:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= K_E;
            r_ovalid     <= 1'b0;
            r_max_torque <= '0;
            r_slip_coef  <= '0;
            r_energy_fr  <= '0;
            r_disc_mass  <= '0;
            r_spec_heat  <= '0;
            r_cool_coef  <= '0;
            r_health     <= (FRAC_BITS+1)'(ONE);
            r_start_temp <= '0;
            r_temp       <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_state == S_IDLE && i_valid) begin
                r_in <= i_data;
            end
            if (r_state == S_MULW) begin
                case (r_step)
                    K_E:   r_e    <= e_q;
                    K_MT1: r_t1   <= m;
                    K_MT:  r_maxt <= m;
                    K_W:   r_w    <= m;
                    K_S1:  r_t1   <= m;
                    K_S2:  r_t1   <= m;
                    K_SY:  r_sync <= m;
                    K_TT:  r_tt   <= tt_clamp;
                    K_PW:  r_pw   <= m[31] ? -34'(m) : 34'(m);
                    K_EN:  r_en   <= m;
                    K_HI:  r_hi   <= m;
                    K_CAP: r_cap  <= m;
                    K_C1:  r_t1   <= m;
                    K_C2:  r_cool <= m;
                    default: ;
                endcase
            end
            if (r_state == S_DIVW && div_done) begin
                case (r_step)
                    K_DH: r_temp <= sat33(33'(r_temp) + 33'(q));
                    default: ;
                endcase
            end
            if (fin) begin
                r_temp <= fin_temp;
            end
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid                 <= 1'b1;
                r_out.engagement_percent <= eng_pct[22:0];
                r_out.passed_torque      <= r_tt;
                r_out.slip_speed         <= slip_sat;
                r_out.disc_temp          <= r_temp;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_TORQUE: r_max_torque <= i_cfg_data;
                    CFG_SLIP_COEF:  r_slip_coef  <= i_cfg_data;
                    CFG_ENERGY_FR:  r_energy_fr  <= i_cfg_data[16:0];
                    CFG_DISC_MASS:  r_disc_mass  <= i_cfg_data;
                    CFG_SPEC_HEAT:  r_spec_heat  <= i_cfg_data;
                    CFG_COOL_COEF:  r_cool_coef  <= i_cfg_data;
                    CFG_HEALTH: begin
                        r_health <= (FRAC_BITS+1)'((health_in > ONE) ? ONE : health_in);
                    end
                    CFG_START_TEMP: begin
                        r_start_temp <= $signed(i_cfg_data);
                        r_temp       <= $signed(i_cfg_data);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_cfg_ready = (r_state == S_IDLE);

    `CTTS_ASSERT_NEXT(a_busy_after_beat, i_valid && !o_stall, o_stall, "no busy after input beat")
    `CTTS_ASSERT(a_idle_div_quiet, !o_stall, !div_busy, "divider running while idle")
    `CTTS_ASSERT(a_temp_floor, $rose(o_valid) && !$past(i_cfg_valid),
        o_data.disc_temp >= r_in.ambient_temp, "disc temperature below ambient")
    `CTTS_ASSERT(a_start_temp_load, $past(i_cfg_valid && o_cfg_ready) && $past(i_cfg_index) == CFG_START_TEMP,
        r_temp == r_start_temp, "start temperature not loaded")

endmodule
